// ===== hw/rtl/rpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rpe_pkg: rooted Prufer encoder package
// Sizes, the sequencer state type and the leaf search result type.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_VERTICES);
  localparam int unsigned VC_W         = IDX_W + 1;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned COUNT_LIMIT  = 127;
  localparam int unsigned MAX_RESULTS  = 63;
  localparam int unsigned RES_W        = 6;
  localparam int unsigned GRP_W        = 8;
  localparam int unsigned N_GRP        = MAX_VERTICES / GRP_W;
  localparam int unsigned GIDX_W       = $clog2(GRP_W);
  localparam int unsigned NGIDX_W      = $clog2(N_GRP);

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } leaf_hit_t;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_DRAIN = 6'b000010,
    S_FIND0 = 6'b000100,
    S_FIND1 = 6'b001000,
    S_READP = 6'b010000,
    S_READC = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/rpe_if.sv =====
// ----------------------------------------------------------------------------
// rpe_if: rooted Prufer encoder channels
// Vertex input channel and code output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpe_vertex_if;
  logic                      valid;
  logic                      ready;
  logic [rpe_pkg::IDX_W-1:0] parent_index;
  logic                      is_root;
  logic                      last_vertex;

  modport source (output valid, parent_index, is_root, last_vertex, input ready);
  modport sink   (input valid, parent_index, is_root, last_vertex, output ready);
endinterface

interface rpe_code_if;
  logic                      valid;
  logic                      ready;
  logic [rpe_pkg::IDX_W-1:0] code_value;
  logic                      last_code;

  modport source (output valid, code_value, last_code, input ready);
  modport sink   (input valid, code_value, last_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rpe_ram.sv =====
// ----------------------------------------------------------------------------
// rpe_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rpe_leaf_find.sv =====
// ----------------------------------------------------------------------------
// rpe_leaf_find: lowest candidate leaf search
// Registered two-level priority tree: per-group lowest bit, then lowest group.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_leaf_find (
  input  logic                              clk_i,
  input  logic [rpe_pkg::MAX_VERTICES-1:0]  cand_i,
  output rpe_pkg::leaf_hit_t                hit_o
);
  import rpe_pkg::*;

  logic [N_GRP-1:0]  grp_any_d, grp_any_q;
  logic [GIDX_W-1:0] grp_low_d [N_GRP];
  logic [GIDX_W-1:0] grp_low_q [N_GRP];

  always_comb begin
    for (int g = 0; g < N_GRP; g++) begin
      grp_any_d[g] = |cand_i[g*GRP_W +: GRP_W];
      grp_low_d[g] = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (cand_i[g*GRP_W + b]) begin
          grp_low_d[g] = GIDX_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    for (int g = 0; g < N_GRP; g++) begin
      grp_low_q[g] <= grp_low_d[g];
    end
  end

  always_comb begin
    hit_o = '0;
    for (int g = N_GRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        hit_o.found = 1'b1;
        hit_o.idx   = {NGIDX_W'(g), grp_low_q[g]};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rooted_prufer_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// rooted_prufer_encoder_unit: rooted tree to Prufer code encoder
// Loads a parent array, then emits the code by repeated lowest-leaf removal.
// ----------------------------------------------------------------------------
// Usage:
//   vertex_i takes one vertex per transfer, vertex 0 first: its parent index,
//   a root flag and a last-vertex flag. Loading runs at one vertex per cycle.
//   After the last vertex the input is held off while the code is produced.
//   code_o gives one code element per transfer; last_code marks the final one.
//   A tree of N vertices yields N-1 codes (at most 63), none for one vertex.
// Timing:
//   A drain step follows the last vertex, then each code runs through leaf
//   search in a registered priority tree, parent RAM read and child count
//   RAM read-modify-write (skipped when a root is picked). A code is
//   handed to the output register when the following search decides whether
//   more codes follow. Input is ready again the cycle after the final code
//   is handed over.
// Reset and stalls:
//   Reset clears all flags and counts; the encoder starts ready to load.
//   If code_o is stalled the sequencer waits in its search step; nothing is
//   lost. Vertices past 64 are dropped, their last flag is still honored.
// ----------------------------------------------------------------------------
`default_nettype none

module rooted_prufer_encoder_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  rpe_vertex_if.sink vertex_i,
  rpe_code_if.source code_o
);
  import rpe_pkg::*;

  state_e state_q, state_d;

  logic [VC_W-1:0]         vc_q, vc_d;
  logic [VC_W-1:0]         nr_q, nr_d;
  logic [RES_W-1:0]        n_q, n_d;
  logic [MAX_VERTICES-1:0] present_q, present_d;
  logic [MAX_VERTICES-1:0] leaf_q, leaf_d;
  logic [MAX_VERTICES-1:0] loaded_q, loaded_d;
  logic [MAX_VERTICES-1:0] cvalid_q, cvalid_d;

  logic              ld_vld_q, ld_vld_d;
  logic [IDX_W-1:0]  ld_addr_q, ld_addr_d;
  logic              wb_en_q, wb_en_d;
  logic [IDX_W-1:0]  wb_addr_q, wb_addr_d;
  logic [CNT_W-1:0]  wb_val_q, wb_val_d;
  logic [IDX_W-1:0]  p_q, p_d;
  logic              pend_vld_q, pend_vld_d;
  logic [IDX_W-1:0]  pend_code_q, pend_code_d;
  logic              out_vld_q, out_vld_d;
  logic [IDX_W-1:0]  out_code_q, out_code_d;
  logic              out_last_q, out_last_d;

  logic              in_fire, full, out_free, cont;
  logic [CNT_W-1:0]  ld_old, ld_new, rc_old, rc_new;
  logic [MAX_VERTICES-1:0] cand;
  leaf_hit_t         hit;

  logic              pram_we;
  logic [IDX_W:0]    pram_rd;
  logic              cram_we;
  logic [IDX_W-1:0]  cram_waddr, cram_raddr;
  logic [CNT_W-1:0]  cram_wdata, cram_rd;

  assign vertex_i.ready    = (state_q == S_LOAD);
  assign code_o.valid      = out_vld_q;
  assign code_o.code_value = out_code_q;
  assign code_o.last_code  = out_last_q;

  assign in_fire  = vertex_i.valid && vertex_i.ready;
  assign full     = (vc_q == VC_W'(MAX_VERTICES));
  assign out_free = !out_vld_q || code_o.ready;
  assign cand     = present_q & leaf_q & loaded_q;
  assign pram_we  = in_fire && !full;
  assign cont     = (n_q != RES_W'(MAX_RESULTS)) && (nr_q != '0) && hit.found;

  rpe_leaf_find u_leaf_find (
    .clk_i  (clk_i),
    .cand_i (cand),
    .hit_o  (hit)
  );

  // parent RAM word: {root mark, parent index}
  rpe_ram #(
    .WIDTH (IDX_W + 1),
    .DEPTH (MAX_VERTICES)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (pram_we),
    .waddr_i (vc_q[IDX_W-1:0]),
    .wdata_i ({vertex_i.is_root, vertex_i.parent_index}),
    .raddr_i (hit.idx),
    .rdata_o (pram_rd)
  );

  rpe_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_VERTICES)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cram_we),
    .waddr_i (cram_waddr),
    .wdata_i (cram_wdata),
    .raddr_i (cram_raddr),
    .rdata_o (cram_rd)
  );

  // load increment: forward the previous cycle's write, unwritten entries read 0
  always_comb begin
    if (wb_en_q && (wb_addr_q == ld_addr_q)) begin
      ld_old = wb_val_q;
    end else if (cvalid_q[ld_addr_q]) begin
      ld_old = cram_rd;
    end else begin
      ld_old = '0;
    end
    ld_new = (ld_old < CNT_W'(COUNT_LIMIT)) ? ld_old + CNT_W'(1) : ld_old;
    rc_old = cvalid_q[p_q] ? cram_rd : '0;
    rc_new = (rc_old != '0) ? rc_old - CNT_W'(1) : '0;
  end

  assign cram_we    = ld_vld_q || (state_q == S_READC);
  assign cram_waddr = ld_vld_q ? ld_addr_q : p_q;
  assign cram_wdata = ld_vld_q ? ld_new : rc_new;
  assign cram_raddr = (state_q == S_READP) ? pram_rd[IDX_W-1:0] : vertex_i.parent_index;

  always_comb begin
    state_d     = state_q;
    vc_d        = vc_q;
    nr_d        = nr_q;
    n_d         = n_q;
    present_d   = present_q;
    leaf_d      = leaf_q;
    loaded_d    = loaded_q;
    cvalid_d    = cvalid_q;
    ld_vld_d    = 1'b0;
    ld_addr_d   = ld_addr_q;
    wb_en_d     = ld_vld_q;
    wb_addr_d   = ld_addr_q;
    wb_val_d    = ld_new;
    p_d         = p_q;
    pend_vld_d  = pend_vld_q;
    pend_code_d = pend_code_q;
    out_vld_d   = out_vld_q && !code_o.ready;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;

    if (ld_vld_q) begin
      cvalid_d[ld_addr_q] = 1'b1;
    end

    unique case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (!full) begin
            loaded_d[vc_q[IDX_W-1:0]] = 1'b1;
            vc_d = vc_q + VC_W'(1);
            if (!vertex_i.is_root) begin
              leaf_d[vertex_i.parent_index] = 1'b0;
              ld_vld_d  = 1'b1;
              ld_addr_d = vertex_i.parent_index;
              nr_d      = nr_q + VC_W'(1);
            end
          end
          if (vertex_i.last_vertex) begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: state_d = S_FIND0;
      S_FIND0: state_d = S_FIND1;
      S_FIND1: begin
        // the held code is final when no further removal follows
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_code_d = pend_code_q;
            out_last_d = !cont;
            pend_vld_d = 1'b0;
          end
          if (cont) begin
            present_d[hit.idx] = 1'b0;
            n_d     = n_q + RES_W'(1);
            state_d = S_READP;
          end else begin
            present_d = '1;
            leaf_d    = '1;
            loaded_d  = '0;
            cvalid_d  = '0;
            vc_d      = '0;
            nr_d      = '0;
            n_d       = '0;
            wb_en_d   = 1'b0;
            state_d   = S_LOAD;
          end
        end
      end
      S_READP: begin
        pend_vld_d = 1'b1;
        if (pram_rd[IDX_W]) begin
          pend_code_d = '0;
          state_d     = S_FIND0;
        end else begin
          pend_code_d = pram_rd[IDX_W-1:0];
          p_d         = pram_rd[IDX_W-1:0];
          nr_d        = nr_q - VC_W'(1);
          state_d     = S_READC;
        end
      end
      S_READC: begin
        cvalid_d[p_q] = 1'b1;
        if (rc_new == '0) begin
          leaf_d[p_q] = 1'b1;
        end
        state_d = S_FIND0;
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      vc_q       <= '0;
      nr_q       <= '0;
      n_q        <= '0;
      present_q  <= '1;
      leaf_q     <= '1;
      loaded_q   <= '0;
      cvalid_q   <= '0;
      ld_vld_q   <= 1'b0;
      wb_en_q    <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      vc_q       <= vc_d;
      nr_q       <= nr_d;
      n_q        <= n_d;
      present_q  <= present_d;
      leaf_q     <= leaf_d;
      loaded_q   <= loaded_d;
      cvalid_q   <= cvalid_d;
      ld_vld_q   <= ld_vld_d;
      wb_en_q    <= wb_en_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_addr_q   <= ld_addr_d;
    wb_addr_q   <= wb_addr_d;
    wb_val_q    <= wb_val_d;
    p_q         <= p_d;
    pend_code_q <= pend_code_d;
    out_code_q  <= out_code_d;
    out_last_q  <= out_last_d;
  end

  // a held code never survives into the load phase
  a_no_pend_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |-> !pend_vld_q)
    else $error("pending code left over in load phase");

  // load-side count update only while loading or draining
  a_ld_stage_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_vld_q |-> ((state_q == S_LOAD) || (state_q == S_DRAIN)))
    else $error("load count update outside load phase");

  // a stalled output holds the sequencer in the search step
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIND1) && pend_vld_q && out_vld_q && !code_o.ready)
    |=> (state_q == S_FIND1))
    else $error("sequencer moved on while output stalled");

  // remaining non-root count never exceeds the loaded vertices
  a_nonroot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nr_q <= vc_q)
    else $error("non-root count above vertex count");

endmodule

`default_nettype wire
